### rtl/ssl_pkg.sv
// Shared sizes, codes and the power-up calibration table of the sensor smoothing and
// linearising core. No dependencies; imported by the core module.

package ssl_pkg;

  // Sizing of the block.
  localparam int SENSOR_COUNT = 4;
  localparam int CAL_POINTS   = 15;
  localparam int SMOOTH_DEPTH = 8;

  // Widths fixed by the item and register fields.
  localparam int SENSOR_W    = 2;
  localparam int CAL_POINT_W = 4;
  localparam int LEVEL_W     = 12;
  localparam int CFG_W       = 10;
  localparam int DIST_W      = 14;
  localparam int CFG_IDX_W   = 1;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Derived widths.
  localparam int PT_IW    = (CAL_POINTS > 1) ? $clog2(CAL_POINTS) : 1;
  localparam int POS_W    = (SMOOTH_DEPTH > 1) ? $clog2(SMOOTH_DEPTH) : 1;
  localparam int TOT_W    = LEVEL_W + $clog2(SMOOTH_DEPTH);
  localparam int PROD_W   = LEVEL_W + DIST_W;
  localparam int NUM_W    = (PROD_W > TOT_W) ? PROD_W : TOT_W;
  localparam int CNT_W    = $clog2(NUM_W + 1);
  localparam int PD_RAW_W = CFG_W + PT_IW + 1;
  localparam int PD_W     = (PD_RAW_W > DIST_W) ? PD_RAW_W : DIST_W + 1;

  localparam int HIST_DEPTH = SENSOR_COUNT * SMOOTH_DEPTH;
  localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int CAL_DEPTH  = SENSOR_COUNT * CAL_POINTS;
  localparam int CAL_AW     = (CAL_DEPTH > 1) ? $clog2(CAL_DEPTH) : 1;

  localparam bit DEPTH_POW2 = ((SMOOTH_DEPTH & (SMOOTH_DEPTH - 1)) == 0);
  localparam int DEPTH_SH   = $clog2(SMOOTH_DEPTH);

  // Floored average by a rounded-up constant reciprocal when the ring depth is not a
  // power of two; exact for every total that fits in TOT_W bits.
  localparam int AVG_SH     = TOT_W + DEPTH_SH;
  localparam int AVG_RECIP  = ((1 << AVG_SH) + SMOOTH_DEPTH - 1) / SMOOTH_DEPTH;
  localparam int AVG_PROD_W = 2 * TOT_W + 1;

  // Item commands.
  localparam logic CMD_CONVERT = 1'b0;
  localparam logic CMD_WRITE   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NEAR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP = 1'b1;

  localparam logic [CFG_W-1:0] NEAR_RESET = 10'd10;
  localparam logic [CFG_W-1:0] STEP_RESET = 10'd10;

  typedef enum logic [1:0] {
    ST_INTERP = 2'd0,
    ST_NEAR   = 2'd1,
    ST_FAR    = 2'd2,
    ST_NONE   = 2'd3
  } status_t;

  // Power-up calibration words; points beyond this table start at zero.
  localparam int DEF_SENSORS = 4;
  localparam int DEF_POINTS  = 15;

  localparam logic [LEVEL_W-1:0] CAL_TABLE [DEF_SENSORS][DEF_POINTS] = '{
    '{12'd3863, 12'd3860, 12'd3793, 12'd3680, 12'd3333, 12'd2453, 12'd1975, 12'd1558,
      12'd1300, 12'd1063, 12'd860,  12'd720,  12'd600,  12'd500,  12'd400},
    '{12'd3865, 12'd3850, 12'd3825, 12'd3765, 12'd3610, 12'd3095, 12'd2513, 12'd2210,
      12'd1927, 12'd1705, 12'd1490, 12'd1245, 12'd1185, 12'd1085, 12'd1120},
    '{12'd3866, 12'd3850, 12'd3832, 12'd3795, 12'd3730, 12'd3530, 12'd3025, 12'd2595,
      12'd2258, 12'd1982, 12'd1762, 12'd1523, 12'd1435, 12'd1312, 12'd1230},
    '{12'd3863, 12'd3860, 12'd3793, 12'd3680, 12'd3333, 12'd2453, 12'd1975, 12'd1558,
      12'd1300, 12'd1063, 12'd860,  12'd720,  12'd600,  12'd500,  12'd400}
  };

  function automatic logic [LEVEL_W-1:0] cal_default_word(
    input logic [SENSOR_W-1:0] s,
    input logic [PT_IW-1:0]    p
  );
    logic [LEVEL_W-1:0] w;
    w = '0;
    if (32'(p) < DEF_POINTS) begin
      w = CAL_TABLE[s][4'(p)];
    end
    return w;
  endfunction

  // Distance of calibration point i, saturated to the output range.
  function automatic logic [DIST_W-1:0] point_dist(
    input logic [CFG_W-1:0] near,
    input logic [CFG_W-1:0] step,
    input logic [PT_IW-1:0] i
  );
    logic [PD_W-1:0] sum;
    sum = PD_W'(near) + PD_W'(i) * PD_W'(step);
    return (sum > PD_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(sum);
  endfunction

endpackage

### rtl/sensor_smooth_and_linearize_core.sv
// Sensor smoothing and linearising core: moving average per sensor and piecewise
// linear conversion to millimetres. Depends on ssl_pkg.

// Each convert item stores a 12-bit sample in its sensor's ring of the last SMOOTH_DEPTH
// samples, keeps a running total of that ring and forms the floored average, which is
// then mapped to millimetres through the sensor's calibration words (point i lies at
// near_distance_mm + i * distance_step_mm). An average at or above the first word clamps
// to the near point, one at or below the last word clamps to the far point, and in
// between the first descending interval that holds it is interpolated; if none holds it
// the distance is zero with status "no interval". A write item replaces one calibration
// word and gives no result. The sample history and the calibration words live in two
// single-port synchronous memories with valid bits, so no clearing pass follows reset.
// Items are handled one at a time. How long a convert item takes is set by the
// calibration search, which reads one word a cycle, and by the bit-serial divider,
// which produces one quotient bit a cycle over the 26-bit product. If SMOOTH_DEPTH is
// not a power of two the average comes from a multiplication by a constant reciprocal
// in the same cycle, so the timing does not change. A finished result sits in an output
// register, so the next item is accepted while it waits to be taken.

module sensor_smooth_and_linearize_core
  import ssl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_command,
  input  logic [SENSOR_W-1:0]   in_sensor,
  input  logic [CAL_POINT_W-1:0] in_cal_point,
  input  logic [LEVEL_W-1:0]    in_level,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DIST_W-1:0]     out_distance_mm,
  output logic [LEVEL_W-1:0]    out_smoothed_level,
  output logic [1:0]            out_range_status
);

  typedef enum logic [3:0] {
    S_IDLE,   // waiting for an item
    S_HRD,    // oldest sample available: update ring, total and average
    S_RD0,    // read calibration word zero
    S_CHK0,   // near clamp test
    S_CHKL,   // far clamp test
    S_SRCH,   // interval search, one word a cycle
    S_PD,     // interval distances and differences
    S_MUL,    // product of offset and span
    S_IDIV,   // serial division of the product
    S_CLMP,   // distance of a clamp point
    S_OUT     // hand the result to the output register
  } state_t;

  localparam logic [PT_IW-1:0] LAST_PT = PT_IW'(CAL_POINTS - 1);

  // Configuration registers.
  logic [CFG_W-1:0] near_r, step_r;

  // Per-sensor ring positions and totals.
  logic [POS_W-1:0] pos_r   [SENSOR_COUNT];
  logic [TOT_W-1:0] total_r [SENSOR_COUNT];

  // Sample history memory with valid bits.
  logic [LEVEL_W-1:0] hist_mem [HIST_DEPTH];
  logic               hist_vld_r [HIST_DEPTH];
  logic [LEVEL_W-1:0] hist_q_r;
  logic               hist_qv_r;

  // Calibration memory with valid bits.
  logic [LEVEL_W-1:0]  cal_mem [CAL_DEPTH];
  logic                cal_vld_r [CAL_DEPTH];
  logic [LEVEL_W-1:0]  cal_q_r;
  logic                cal_qv_r;
  logic [SENSOR_W-1:0] cal_qs_r;
  logic [PT_IW-1:0]    cal_qp_r;

  // Sequencer registers.
  state_t              state_r, state_nxt;
  logic [SENSOR_W-1:0] sensor_r, sensor_nxt;
  logic [LEVEL_W-1:0]  level_r, level_nxt;
  logic [LEVEL_W-1:0]  avg_r, avg_nxt;
  logic [LEVEL_W-1:0]  hi_r, hi_nxt;
  logic [LEVEL_W-1:0]  lo_r, lo_nxt;
  logic [PT_IW-1:0]    idx_r, idx_nxt;
  logic [DIST_W-1:0]   dfar_r, dfar_nxt;
  logic [DIST_W-1:0]   span_r, span_nxt;
  logic [LEVEL_W-1:0]  den_r, den_nxt;
  logic [LEVEL_W-1:0]  diff_r, diff_nxt;
  logic [NUM_W-1:0]    div_num_r, div_num_nxt;
  logic [LEVEL_W-1:0]  div_rem_r, div_rem_nxt;
  logic [LEVEL_W-1:0]  div_den_r, div_den_nxt;
  logic [CNT_W-1:0]    div_cnt_r, div_cnt_nxt;
  logic [DIST_W-1:0]   dist_r, dist_nxt;
  status_t             status_r, status_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0]   out_dist_r, out_dist_nxt;
  logic [LEVEL_W-1:0]  out_avg_r, out_avg_nxt;
  status_t             out_status_r, out_status_nxt;

  // Combinational control.
  logic                in_acc;
  logic                sensor_ok;
  logic                ring_upd;
  logic [POS_W-1:0]    pos_nxt;
  logic [TOT_W-1:0]    tot_nxt;
  logic [AVG_PROD_W-1:0] avg_prod;
  logic [LEVEL_W-1:0]  old_sample;
  logic                hist_rd_en;
  logic [HIST_AW-1:0]  hist_rd_addr;
  logic [HIST_AW-1:0]  hist_wr_addr;
  logic                cal_we;
  logic [CAL_AW-1:0]   cal_wr_addr;
  logic                cal_rd_en;
  logic [PT_IW-1:0]    cal_rd_pt;
  logic [CAL_AW-1:0]   cal_rd_addr;
  logic [LEVEL_W-1:0]  cal_word;
  logic [LEVEL_W:0]    rem_sh;
  logic                q_bit;
  logic [LEVEL_W-1:0]  rem_step;
  logic [NUM_W-1:0]    num_step;
  logic [DIST_W-1:0]   d_near, d_far;
  logic                div_last;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign sensor_ok = (32'(in_sensor) < SENSOR_COUNT);

  assign out_valid          = out_valid_r;
  assign out_distance_mm    = out_dist_r;
  assign out_smoothed_level = out_avg_r;
  assign out_range_status   = out_status_r;

  // Ring bookkeeping for the item in hand.
  assign old_sample = hist_qv_r ? hist_q_r : '0;
  assign tot_nxt    = total_r[sensor_r] - TOT_W'(old_sample) + TOT_W'(level_r);
  assign pos_nxt    = (pos_r[sensor_r] == POS_W'(SMOOTH_DEPTH - 1)) ? '0
                                                                    : pos_r[sensor_r] + 1'b1;
  assign ring_upd   = (state_r == S_HRD);
  assign avg_prod   = AVG_PROD_W'(tot_nxt) * AVG_PROD_W'(AVG_RECIP);

  assign hist_rd_en   = in_acc && sensor_ok && (in_command == CMD_CONVERT);
  assign hist_rd_addr = HIST_AW'(in_sensor * SMOOTH_DEPTH + pos_r[in_sensor]);
  assign hist_wr_addr = HIST_AW'(sensor_r * SMOOTH_DEPTH + pos_r[sensor_r]);

  assign cal_we      = in_acc && sensor_ok && (in_command == CMD_WRITE)
                       && (32'(in_cal_point) < CAL_POINTS);
  assign cal_wr_addr = CAL_AW'(in_sensor * CAL_POINTS + PT_IW'(in_cal_point));
  assign cal_rd_addr = CAL_AW'(sensor_r * CAL_POINTS + cal_rd_pt);
  assign cal_word    = cal_qv_r ? cal_q_r : cal_default_word(cal_qs_r, cal_qp_r);

  // One restoring division step; the remainder always stays below the divisor.
  assign rem_sh   = {div_rem_r, div_num_r[NUM_W-1]};
  assign q_bit    = (rem_sh >= {1'b0, div_den_r});
  assign rem_step = q_bit ? LEVEL_W'(rem_sh - {1'b0, div_den_r}) : LEVEL_W'(rem_sh);
  assign num_step = {div_num_r[NUM_W-2:0], q_bit};
  assign div_last = (div_cnt_r == CNT_W'(1));

  assign d_near = point_dist(near_r, step_r, idx_r);
  assign d_far  = point_dist(near_r, step_r, idx_r + 1'b1);

  // Sample history memory.
  always_ff @(posedge clk) begin
    if (hist_rd_en) begin
      hist_q_r  <= hist_mem[hist_rd_addr];
      hist_qv_r <= hist_vld_r[hist_rd_addr];
    end
    if (ring_upd) begin
      hist_mem[hist_wr_addr] <= level_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_vld_r[i] <= 1'b0;
      end
    end else if (ring_upd) begin
      hist_vld_r[hist_wr_addr] <= 1'b1;
    end
  end

  // Calibration memory.
  always_ff @(posedge clk) begin
    if (cal_rd_en) begin
      cal_q_r  <= cal_mem[cal_rd_addr];
      cal_qv_r <= cal_vld_r[cal_rd_addr];
      cal_qs_r <= sensor_r;
      cal_qp_r <= cal_rd_pt;
    end
    if (cal_we) begin
      cal_mem[cal_wr_addr] <= in_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CAL_DEPTH; i++) begin
        cal_vld_r[i] <= 1'b0;
      end
    end else if (cal_we) begin
      cal_vld_r[cal_wr_addr] <= 1'b1;
    end
  end

  // Sequencer next-state logic.
  always_comb begin
    state_nxt      = state_r;
    sensor_nxt     = sensor_r;
    level_nxt      = level_r;
    avg_nxt        = avg_r;
    hi_nxt         = hi_r;
    lo_nxt         = lo_r;
    idx_nxt        = idx_r;
    dfar_nxt       = dfar_r;
    span_nxt       = span_r;
    den_nxt        = den_r;
    diff_nxt       = diff_r;
    div_num_nxt    = div_num_r;
    div_rem_nxt    = div_rem_r;
    div_den_nxt    = div_den_r;
    div_cnt_nxt    = div_cnt_r;
    dist_nxt       = dist_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_dist_nxt   = out_dist_r;
    out_avg_nxt    = out_avg_r;
    out_status_nxt = out_status_r;
    cal_rd_en      = 1'b0;
    cal_rd_pt      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (hist_rd_en) begin
          sensor_nxt = in_sensor;
          level_nxt  = in_level;
          state_nxt  = S_HRD;
        end
      end

      S_HRD: begin
        if (DEPTH_POW2) begin
          avg_nxt = LEVEL_W'(tot_nxt >> DEPTH_SH);
        end else begin
          avg_nxt = LEVEL_W'(avg_prod >> AVG_SH);
        end
        state_nxt = S_RD0;
      end

      S_RD0: begin
        cal_rd_en = 1'b1;
        cal_rd_pt = '0;
        state_nxt = S_CHK0;
      end

      S_CHK0: begin
        cal_rd_en = 1'b1;
        cal_rd_pt = LAST_PT;
        hi_nxt    = cal_word;
        if (avg_r >= cal_word) begin
          idx_nxt    = '0;
          status_nxt = ST_NEAR;
          state_nxt  = S_CLMP;
        end else begin
          state_nxt = S_CHKL;
        end
      end

      S_CHKL: begin
        if (avg_r <= cal_word) begin
          idx_nxt    = LAST_PT;
          status_nxt = ST_FAR;
          state_nxt  = S_CLMP;
        end else begin
          cal_rd_en = 1'b1;
          cal_rd_pt = PT_IW'(1);
          idx_nxt   = '0;
          state_nxt = S_SRCH;
        end
      end

      S_SRCH: begin
        // cal_word is the word after point idx_r; hi_r is the word at idx_r.
        if (avg_r <= hi_r && avg_r >= cal_word) begin
          lo_nxt    = cal_word;
          state_nxt = S_PD;
        end else if (idx_r == LAST_PT - 1'b1) begin
          dist_nxt   = '0;
          status_nxt = ST_NONE;
          state_nxt  = S_OUT;
        end else begin
          cal_rd_en = 1'b1;
          cal_rd_pt = idx_r + PT_IW'(2);
          hi_nxt    = cal_word;
          idx_nxt   = idx_r + 1'b1;
        end
      end

      S_PD: begin
        dfar_nxt  = d_far;
        span_nxt  = d_far - d_near;
        den_nxt   = hi_r - lo_r;
        diff_nxt  = avg_r - lo_r;
        state_nxt = S_MUL;
      end

      S_MUL: begin
        status_nxt = ST_INTERP;
        if (den_r == '0) begin
          // A flat interval contributes no fraction.
          dist_nxt  = dfar_r;
          state_nxt = S_OUT;
        end else begin
          div_num_nxt = NUM_W'(PROD_W'(diff_r) * PROD_W'(span_r));
          div_rem_nxt = '0;
          div_den_nxt = den_r;
          div_cnt_nxt = CNT_W'(NUM_W);
          state_nxt   = S_IDIV;
        end
      end

      S_IDIV: begin
        div_num_nxt = num_step;
        div_rem_nxt = rem_step;
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_last) begin
          dist_nxt  = dfar_r - DIST_W'(num_step);
          state_nxt = S_OUT;
        end
      end

      S_CLMP: begin
        dist_nxt  = d_near;
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_dist_nxt   = dist_r;
          out_avg_nxt    = avg_r;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Sequencer state, ring bookkeeping, configuration and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      near_r      <= NEAR_RESET;
      step_r      <= STEP_RESET;
      for (int s = 0; s < SENSOR_COUNT; s++) begin
        pos_r[s]   <= '0;
        total_r[s] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_NEAR: near_r <= cfg_wdata;
          REG_STEP: step_r <= cfg_wdata;
          default:  ;
        endcase
      end
      if (ring_upd) begin
        pos_r[sensor_r]   <= pos_nxt;
        total_r[sensor_r] <= tot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    sensor_r     <= sensor_nxt;
    level_r      <= level_nxt;
    avg_r        <= avg_nxt;
    hi_r         <= hi_nxt;
    lo_r         <= lo_nxt;
    idx_r        <= idx_nxt;
    dfar_r       <= dfar_nxt;
    span_r       <= span_nxt;
    den_r        <= den_nxt;
    diff_r       <= diff_nxt;
    div_num_r    <= div_num_nxt;
    div_rem_r    <= div_rem_nxt;
    div_den_r    <= div_den_nxt;
    div_cnt_r    <= div_cnt_nxt;
    dist_r       <= dist_nxt;
    status_r     <= status_nxt;
    out_dist_r   <= out_dist_nxt;
    out_avg_r    <= out_avg_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule
